[design/lpgs_pkg.sv]
// Shared constants for the lattice push-growth block: default lattice sizes, field widths, opcodes, directions.
package lpgs_pkg;

   // Default lattice edge lengths
   localparam int GRID_X_DEFAULT = 32;
   localparam int GRID_Y_DEFAULT = 32;
   localparam int GRID_Z_DEFAULT = 32;

   // Field widths on the ports
   localparam int OP_W    = 1;
   localparam int COORD_W = 5;
   localparam int DIR_W   = 3;

   // Item opcodes
   localparam logic [OP_W-1:0] OP_SEED = 1'b0;
   localparam logic [OP_W-1:0] OP_PUSH = 1'b1;

   // Push rays
   localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd0;
   localparam logic [DIR_W-1:0] DIR_POS_X = 3'd1;
   localparam logic [DIR_W-1:0] DIR_NEG_Y = 3'd2;
   localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd3;
   localparam logic [DIR_W-1:0] DIR_NEG_Z = 3'd4;
   localparam logic [DIR_W-1:0] DIR_POS_Z = 3'd5;

endpackage

[design/lpgs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lpgs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/lattice_push_growth_step.sv]
// Push-growth lattice: occupancy bitmap in RAM, seed and ray-walk push sequencer.
// A seed probes its own cell; a push probes the cells along its ray, one per cycle
// through the bitmap RAM read port, until a free cell or the lattice edge; rejected
// items probe none. ST_FINISH then registers the result once the output is free.
// One item at a time: req_stall stays high until the sequencer is back in ST_IDLE.
// Reset: synchronous; a clearing pass then writes every RAM word,
// 2**(clog2(GRID_X)+clog2(GRID_Y)+clog2(GRID_Z)) words (32768 at defaults),
// during which req_stall stays high.
module lattice_push_growth_step #(
   parameter int GRID_X = lpgs_pkg::GRID_X_DEFAULT,
   parameter int GRID_Y = lpgs_pkg::GRID_Y_DEFAULT,
   parameter int GRID_Z = lpgs_pkg::GRID_Z_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lpgs_pkg::OP_W-1:0]    req_op,
   input  logic [lpgs_pkg::COORD_W-1:0] req_cell_x,
   input  logic [lpgs_pkg::COORD_W-1:0] req_cell_y,
   input  logic [lpgs_pkg::COORD_W-1:0] req_cell_z,
   input  logic [lpgs_pkg::DIR_W-1:0]   req_direction,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_filled,
   output logic [lpgs_pkg::COORD_W-1:0] rsp_fill_x,
   output logic [lpgs_pkg::COORD_W-1:0] rsp_fill_y,
   output logic [lpgs_pkg::COORD_W-1:0] rsp_fill_z
);
   import lpgs_pkg::*;

   localparam int XW    = $clog2(GRID_X);
   localparam int YW    = $clog2(GRID_Y);
   localparam int ZW    = $clog2(GRID_Z);
   localparam int AW    = XW + YW + ZW;
   localparam int DEPTH = 2 ** AW;
   localparam logic [XW-1:0] X_LAST = XW'(GRID_X - 1);
   localparam logic [YW-1:0] Y_LAST = YW'(GRID_Y - 1);
   localparam logic [ZW-1:0] Z_LAST = ZW'(GRID_Z - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_FINISH
   } state_type;

   // One step along a ray: neighbor cell, or a flag that the ray leaves the lattice
   typedef struct packed {
      logic          at_edge;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic [ZW-1:0] z;
   } step_type;

   function automatic step_type ray_step(input logic [XW-1:0]    x,
                                         input logic [YW-1:0]    y,
                                         input logic [ZW-1:0]    z,
                                         input logic [DIR_W-1:0] dir);
      step_type s;
      s.at_edge = 1'b0;
      s.x       = x;
      s.y       = y;
      s.z       = z;
      unique case (dir)
         DIR_NEG_X: if (x == '0)     s.at_edge = 1'b1; else s.x = x - XW'(1);
         DIR_POS_X: if (x == X_LAST) s.at_edge = 1'b1; else s.x = x + XW'(1);
         DIR_NEG_Y: if (y == '0)     s.at_edge = 1'b1; else s.y = y - YW'(1);
         DIR_POS_Y: if (y == Y_LAST) s.at_edge = 1'b1; else s.y = y + YW'(1);
         DIR_NEG_Z: if (z == '0)     s.at_edge = 1'b1; else s.z = z - ZW'(1);
         DIR_POS_Z: if (z == Z_LAST) s.at_edge = 1'b1; else s.z = z + ZW'(1);
         default:   s.at_edge = 1'b1;
      endcase
      return s;
   endfunction

   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic                is_push_ff, is_push_in;
   logic [DIR_W-1:0]    dir_ff, dir_in;
   logic [XW-1:0]       cur_x_ff, cur_x_in;
   logic [YW-1:0]       cur_y_ff, cur_y_in;
   logic [ZW-1:0]       cur_z_ff, cur_z_in;
   logic                res_filled_ff, res_filled_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_filled_ff, rsp_filled_in;
   logic [COORD_W-1:0]  rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0]  rsp_y_ff, rsp_y_in;
   logic [COORD_W-1:0]  rsp_z_ff, rsp_z_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic                ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic                ram_rd_data;

   logic                req_xfer;
   logic                req_in_range;
   logic [XW-1:0]       req_x;
   logic [YW-1:0]       req_y;
   logic [ZW-1:0]       req_z;
   step_type            req_step;
   step_type            cur_step;
   logic                out_free;

   // Request decode
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_xfer     = req_valid && !req_stall;
   assign req_in_range = (int'(req_cell_x) < GRID_X) && (int'(req_cell_y) < GRID_Y)
                      && (int'(req_cell_z) < GRID_Z);
   assign req_x        = XW'(req_cell_x);
   assign req_y        = YW'(req_cell_y);
   assign req_z        = ZW'(req_cell_z);
   assign req_step     = ray_step(req_x, req_y, req_z, req_direction);
   assign cur_step     = ray_step(cur_x_ff, cur_y_ff, cur_z_ff, dir_ff);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Sequencer: clearing pass, request decode, probe loop, result hand-off
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      is_push_in    = is_push_ff;
      dir_in        = dir_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      cur_z_in      = cur_z_ff;
      res_filled_in = res_filled_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_filled_in = rsp_filled_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = {cur_x_ff, cur_y_ff, cur_z_ff};
      ram_wr_data   = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = {cur_step.x, cur_step.y, cur_step.z};

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            clr_cnt_in  = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               is_push_in    = (req_op == OP_PUSH);
               dir_in        = req_direction;
               res_filled_in = 1'b0;
               priority if (!req_in_range) begin
                  state_in = ST_FINISH;
               end else if (req_op == OP_SEED) begin
                  cur_x_in    = req_x;
                  cur_y_in    = req_y;
                  cur_z_in    = req_z;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = {req_x, req_y, req_z};
                  state_in    = ST_PROBE;
               end else if (req_step.at_edge) begin
                  state_in = ST_FINISH;
               end else begin
                  cur_x_in    = req_step.x;
                  cur_y_in    = req_step.y;
                  cur_z_in    = req_step.z;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = {req_step.x, req_step.y, req_step.z};
                  state_in    = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            // Read data belongs to the current cell
            priority if (!ram_rd_data) begin
               ram_wr_en     = 1'b1;
               ram_wr_data   = 1'b1;
               res_filled_in = 1'b1;
               state_in      = ST_FINISH;
            end else if (!is_push_ff || cur_step.at_edge) begin
               res_filled_in = 1'b0;
               state_in      = ST_FINISH;
            end else begin
               cur_x_in  = cur_step.x;
               cur_y_in  = cur_step.y;
               cur_z_in  = cur_step.z;
               ram_rd_en = 1'b1;
               state_in  = ST_PROBE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_filled_in = res_filled_ff;
               rsp_x_in      = res_filled_ff ? COORD_W'(cur_x_ff) : '0;
               rsp_y_in      = res_filled_ff ? COORD_W'(cur_y_ff) : '0;
               rsp_z_in      = res_filled_ff ? COORD_W'(cur_z_ff) : '0;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_push_ff    <= is_push_in;
      dir_ff        <= dir_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      cur_z_ff      <= cur_z_in;
      res_filled_ff <= res_filled_in;
      rsp_filled_ff <= rsp_filled_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
   end

   // Occupancy bitmap, one bit per cell, addressed {x, y, z}
   lpgs_ram #(
      .WIDTH(1),
      .DEPTH(DEPTH)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_filled = rsp_filled_ff;
   assign rsp_fill_x = rsp_x_ff;
   assign rsp_fill_y = rsp_y_ff;
   assign rsp_fill_z = rsp_z_ff;

endmodule

[design/lpgs_checker.sv]
// Port-level assertions for the push-growth block, bound to the top level.
module lpgs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_filled,
   input logic [lpgs_pkg::COORD_W-1:0] rsp_fill_x,
   input logic [lpgs_pkg::COORD_W-1:0] rsp_fill_y,
   input logic [lpgs_pkg::COORD_W-1:0] rsp_fill_z
);
   import lpgs_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filled) && $stable(rsp_fill_x)
                                && $stable(rsp_fill_y) && $stable(rsp_fill_z))
      else $error("stalled result changed");

   // No fill reports zero coordinates
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_filled |-> rsp_fill_x == '0 && rsp_fill_y == '0 && rsp_fill_z == '0)
      else $error("unfilled result with nonzero coordinates");

   // Reset drops any pending result
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Clearing pass blocks requests after reset
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // One item at a time: a transfer in stalls the channel next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("back-to-back request transfers");

endmodule

bind lattice_push_growth_step lpgs_checker u_lpgs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_filled(rsp_filled),
   .rsp_fill_x(rsp_fill_x),
   .rsp_fill_y(rsp_fill_y),
   .rsp_fill_z(rsp_fill_z)
);
